### hdl/tes_pkg.sv
package tes_pkg;

	// Character codes that the filter recognises.
	localparam logic [7:0] CH_ESC      = 8'h1b;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_LBRACKET = 8'h5b;

	// Byte classes inside a control sequence.
	localparam logic [7:0] PARAM_LO = 8'h30;
	localparam logic [7:0] PARAM_HI = 8'h3f;
	localparam logic [7:0] INTER_LO = 8'h20;
	localparam logic [7:0] INTER_HI = 8'h2f;
	localparam logic [7:0] FINAL_LO = 8'h40;
	localparam logic [7:0] FINAL_HI = 8'h7e;

	// Depth of the command queue between the parser and the overstrike filter.
	localparam int unsigned CMD_FIFO_DEPTH = 4;

	// Command from the parser: feed one byte, or close the stream.
	typedef enum logic {
		CMD_FEED = 1'b0,
		CMD_EOS  = 1'b1
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
		logic       run_end;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

### hdl/tes_if.sv
interface tes_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_final;

	modport source (output valid, output in_byte, output is_final, input ready);
	modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface tes_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_stream;
	logic       run_done;

	modport source (output valid, output out_byte, output byte_valid,
		output end_of_stream, output run_done, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input end_of_stream, input run_done, output ready);
endinterface

### hdl/tes_cmd_fifo.sv
module tes_cmd_fifo import tes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_req_t push,
	output logic     push_ready,
	output cmd_req_t pop,
	input  logic     pop_ready
);

	localparam int unsigned PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             entry_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(CMD_FIFO_DEPTH));
	assign pop.valid  = (fill_q != '0);
	assign pop.cmd    = entry_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

### hdl/tes_front.sv
module tes_front import tes_pkg::*; #(
	parameter int unsigned HOLD_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	tes_in_if.sink   in_ch,
	output cmd_req_t push,
	input  logic     push_ready
);

	localparam int unsigned ADDR_W = $clog2(HOLD_DEPTH);
	localparam int unsigned CNT_W  = $clog2(HOLD_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_ESC   = 4'b0010,
		PH_PARAM = 4'b0100,
		PH_INTER = 4'b1000
	} phase_t;

	typedef enum logic [4:0] {
		SQ_RUN  = 5'b00001,
		SQ_RD   = 5'b00010,
		SQ_REL  = 5'b00100,
		SQ_TAIL = 5'b01000,
		SQ_EOS  = 5'b10000
	} seq_t;

	phase_t            phase_q;
	seq_t              seq_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] idx_q;
	logic              tail_feed_q;
	logic              tail_hold_q;
	logic              eos_q;
	logic [7:0]        tail_byte_q;
	logic [7:0]        hold_mem [HOLD_DEPTH];
	logic [7:0]        rdata_q;

	logic [7:0]        b;
	logic              last;
	logic              is_esc;
	logic              is_param;
	logic              is_inter;
	logic              is_fin;
	logic              in_pi;
	logic              keep;
	phase_t            keep_ph;
	logic              room;
	logic              accept;

	logic              act_write;
	logic              act_push;
	logic              act_seq;
	logic              act_rel;
	logic              act_feed;
	logic              act_hold;
	phase_t            phase_n;
	logic [CNT_W-1:0]  count_n;

	logic              rel_last;
	logic              hold_done;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;

	assign b        = in_ch.in_byte;
	assign last     = in_ch.is_final;
	assign is_esc   = (b == CH_ESC);
	assign is_param = (b >= PARAM_LO) && (b <= PARAM_HI);
	assign is_inter = (b >= INTER_LO) && (b <= INTER_HI);
	assign is_fin   = (b >= FINAL_LO) && (b <= FINAL_HI);
	assign in_pi    = (phase_q == PH_PARAM) || (phase_q == PH_INTER);
	assign room     = (count_q < CNT_W'(HOLD_DEPTH));

	assign in_ch.ready = (seq_q == SQ_RUN) && push_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Whether the byte may extend the open sequence, and into which phase.
	always_comb begin
		keep    = 1'b0;
		keep_ph = PH_IDLE;
		if ((phase_q == PH_ESC) && (b == CH_LBRACKET)) begin
			keep    = 1'b1;
			keep_ph = PH_PARAM;
		end else if ((phase_q == PH_PARAM) && is_param) begin
			keep    = 1'b1;
			keep_ph = PH_PARAM;
		end else if (in_pi && is_inter) begin
			keep    = 1'b1;
			keep_ph = PH_INTER;
		end
	end

	// Classification of an incoming byte. Anything that needs more than one
	// command, or the held run, goes to the sequencer.
	always_comb begin
		act_write = 1'b0;
		act_push  = 1'b0;
		act_seq   = 1'b0;
		act_rel   = 1'b0;
		act_feed  = 1'b0;
		act_hold  = 1'b0;
		phase_n   = phase_q;
		count_n   = count_q;
		if (phase_q == PH_IDLE) begin
			if (is_esc && !last) begin
				act_write = 1'b1;
				phase_n   = PH_ESC;
				count_n   = CNT_W'(1);
			end else if (last) begin
				act_seq  = 1'b1;
				act_feed = 1'b1;
			end else begin
				act_push = 1'b1;
			end
		end else if (in_pi && is_fin) begin
			// A complete sequence vanishes.
			phase_n = PH_IDLE;
			count_n = '0;
			act_seq = last;
		end else if (keep && room) begin
			if (!last) begin
				act_write = 1'b1;
				phase_n   = keep_ph;
				count_n   = count_q + CNT_W'(1);
			end else begin
				act_seq  = 1'b1;
				act_rel  = 1'b1;
				act_feed = 1'b1;
			end
		end else begin
			// Broken or overflowing sequence: release it, then handle the byte.
			act_seq  = 1'b1;
			act_rel  = 1'b1;
			act_hold = is_esc && !last;
			act_feed = !(is_esc && !last);
		end
	end

	assign rel_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign hold_done = (seq_q == SQ_REL) && push_ready && rel_last
		&& !tail_feed_q && tail_hold_q;

	// Commands towards the queue.
	always_comb begin
		push = '0;
		unique case (seq_q)
			SQ_RUN: begin
				push.valid       = in_ch.valid && act_push;
				push.cmd.op      = CMD_FEED;
				push.cmd.data    = b;
				push.cmd.run_end = 1'b1;
			end
			SQ_RD: begin
				push.valid = 1'b0;
			end
			SQ_REL: begin
				push.valid       = 1'b1;
				push.cmd.op      = CMD_FEED;
				push.cmd.data    = rdata_q;
				push.cmd.run_end = rel_last && !tail_feed_q && !eos_q;
			end
			SQ_TAIL: begin
				push.valid       = 1'b1;
				push.cmd.op      = CMD_FEED;
				push.cmd.data    = tail_byte_q;
				push.cmd.run_end = !eos_q;
			end
			SQ_EOS: begin
				push.valid       = 1'b1;
				push.cmd.op      = CMD_EOS;
				push.cmd.data    = 8'h00;
				push.cmd.run_end = 1'b1;
			end
			default: begin
				push = '0;
			end
		endcase
	end

	// Held run memory: one write port, one registered read port.
	assign mem_we = (accept && act_write) || hold_done;
	assign mem_wa = hold_done ? '0 : count_q[ADDR_W-1:0];
	assign mem_wd = hold_done ? CH_ESC : b;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hold_mem[mem_wa] <= mem_wd;
		end
		rdata_q <= hold_mem[idx_q];
	end

	// Tail of a sequenced request, kept while the held run drains.
	always_ff @(posedge clk) begin
		if (accept && act_seq) begin
			tail_byte_q <= b;
		end
	end

	// Parser phase and release sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seq_q       <= SQ_RUN;
			count_q     <= '0;
			idx_q       <= '0;
			tail_feed_q <= 1'b0;
			tail_hold_q <= 1'b0;
			eos_q       <= 1'b0;
		end else begin
			unique case (seq_q)
				SQ_RUN: begin
					if (accept) begin
						if (act_seq) begin
							phase_q     <= PH_IDLE;
							idx_q       <= '0;
							tail_feed_q <= act_feed;
							tail_hold_q <= act_hold;
							eos_q       <= last;
							if (act_rel) begin
								seq_q <= SQ_RD;
							end else begin
								count_q <= '0;
								seq_q   <= act_feed ? SQ_TAIL : SQ_EOS;
							end
						end else begin
							phase_q <= phase_n;
							count_q <= count_n;
						end
					end
				end
				SQ_RD: begin
					seq_q <= SQ_REL;
				end
				SQ_REL: begin
					if (push_ready) begin
						if (rel_last) begin
							if (tail_feed_q) begin
								count_q <= '0;
								seq_q   <= SQ_TAIL;
							end else if (tail_hold_q) begin
								// A new sequence opens with the breaking ESC.
								count_q <= CNT_W'(1);
								phase_q <= PH_ESC;
								seq_q   <= SQ_RUN;
							end else begin
								count_q <= '0;
								seq_q   <= eos_q ? SQ_EOS : SQ_RUN;
							end
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
							seq_q <= SQ_RD;
						end
					end
				end
				SQ_TAIL: begin
					if (push_ready) begin
						seq_q <= eos_q ? SQ_EOS : SQ_RUN;
					end
				end
				SQ_EOS: begin
					if (push_ready) begin
						phase_q <= PH_IDLE;
						count_q <= '0;
						seq_q   <= SQ_RUN;
					end
				end
				default: begin
					seq_q <= SQ_RUN;
				end
			endcase
		end
	end

endmodule

### hdl/tes_back.sv
module tes_back import tes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_req_t pop,
	output logic     pop_ready,
	tes_out_if.source out_ch
);

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       eos;
	} res_t;

	logic       pend_v_q;
	logic [7:0] pend_b_q;
	logic       cand_v_q;
	res_t       cand_q;
	logic       flush_q;
	logic       out_v_q;
	res_t       out_q;
	logic       out_rd_q;

	logic       slot;
	logic       has_r;
	res_t       r;
	logic       pend_v_n;
	logic [7:0] pend_b_n;

	assign slot      = !out_v_q || out_ch.ready;
	assign pop_ready = slot && !flush_q;

	assign out_ch.valid         = out_v_q;
	assign out_ch.out_byte      = out_q.data;
	assign out_ch.byte_valid    = out_q.byte_valid;
	assign out_ch.end_of_stream = out_q.eos;
	assign out_ch.run_done      = out_rd_q;

	// Overstrike filter: one byte waits until its successor is known.
	always_comb begin
		has_r    = 1'b0;
		r        = '0;
		pend_v_n = pend_v_q;
		pend_b_n = pend_b_q;
		case (pop.cmd.op)
			CMD_FEED: begin
				if (pend_v_q && (pop.cmd.data == CH_BS)) begin
					pend_v_n = 1'b0;
				end else begin
					has_r    = pend_v_q;
					r        = '{data: pend_b_q, byte_valid: 1'b1, eos: 1'b0};
					pend_b_n = pop.cmd.data;
					pend_v_n = 1'b1;
				end
			end
			CMD_EOS: begin
				has_r    = 1'b1;
				r        = pend_v_q ? '{data: pend_b_q, byte_valid: 1'b1, eos: 1'b1}
					: '{data: 8'h00, byte_valid: 1'b0, eos: 1'b1};
				pend_v_n = 1'b0;
				pend_b_n = 8'h00;
			end
			default: begin
				has_r = 1'b0;
			end
		endcase
	end

	// A result is held back as a candidate while later commands of the same
	// request might still produce one, so that the last one carries run_done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_b_q <= 8'h00;
			cand_v_q <= 1'b0;
			cand_q   <= '0;
			flush_q  <= 1'b0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
			out_rd_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (slot) begin
				if (flush_q) begin
					out_v_q  <= 1'b1;
					out_q    <= cand_q;
					out_rd_q <= 1'b1;
					cand_v_q <= 1'b0;
					flush_q  <= 1'b0;
				end else if (pop.valid) begin
					pend_v_q <= pend_v_n;
					pend_b_q <= pend_b_n;
					if (cand_v_q && has_r) begin
						out_v_q  <= 1'b1;
						out_q    <= cand_q;
						out_rd_q <= 1'b0;
						cand_q   <= r;
						flush_q  <= pop.cmd.run_end;
					end else if (cand_v_q && pop.cmd.run_end) begin
						out_v_q  <= 1'b1;
						out_q    <= cand_q;
						out_rd_q <= 1'b1;
						cand_v_q <= 1'b0;
					end else if (has_r && pop.cmd.run_end) begin
						out_v_q  <= 1'b1;
						out_q    <= r;
						out_rd_q <= 1'b1;
					end else if (has_r) begin
						cand_v_q <= 1'b1;
						cand_q   <= r;
					end
				end
			end
		end
	end

endmodule

### hdl/terminal_escape_stripper_unit.sv
// Strips complete CSI escape sequences and backspace overstrikes from a byte
// stream. Ordinary bytes pass at one per cycle while the command queue has
// room; a byte is delivered once its successor has arrived, so output trails
// input by one byte until the stream ends. Bytes of an open sequence are held
// in a HOLD_DEPTH-entry memory; when a sequence breaks (or a stream ends in
// it) the held bytes are read back through its registered port, each byte
// passing a read state and a release state, and the input waits for that. It
// also waits while the byte that broke the sequence is sent, unless that byte
// is an escape that opens a new one, and while the end marker is sent. For a
// last byte with nothing held, it waits while that byte and the marker are
// sent. A request whose results come from more than one released byte may
// need a separate output flush to flag its last result. A four-entry command
// queue separates the parser from the overstrike filter; output is registered.
module terminal_escape_stripper_unit import tes_pkg::*; #(
	parameter int unsigned HOLD_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tes_in_if.sink    in_ch,
	tes_out_if.source out_ch
);

	cmd_req_t push;
	logic     push_ready;
	cmd_req_t pop;
	logic     pop_ready;

	// Sequence parser and release sequencer.
	tes_front #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push       (push),
		.push_ready (push_ready)
	);

	// Command queue.
	tes_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	// Overstrike filter and output register.
	tes_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_ready (pop_ready),
		.out_ch    (out_ch)
	);

endmodule
